>>> rtl/lewc_pkg.sv
`timescale 1ns / 1ps
package lewc_pkg;

  localparam int WORD_W        = 18;
  localparam int CNT_W         = 12;
  localparam int TOTAL_W       = 16;
  localparam int POS_W         = 29;
  localparam int POLE_BITS_DEF = 16;
  localparam int QDEPTH        = 2;

  // sensor word bit positions
  localparam int CNT_LSB = 6;
  localparam int OCF_BIT = 5;
  localparam int COF_BIT = 4;
  localparam int LIN_BIT = 3;
  localparam int INC_BIT = 2;
  localparam int DEC_BIT = 1;

  localparam logic [CNT_W-1:0] HIGH_THR_RST = 12'd3686;
  localparam logic [CNT_W-1:0] LOW_THR_RST  = 12'd410;

  typedef enum logic {
    CFG_HIGH_THR = 1'b0,
    CFG_LOW_THR  = 1'b1
  } cfg_idx_t;

  // one classified sensor reading
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             par_ok;
    logic             ocf;
    logic             cof;
    logic             lin;
    logic             inc;
    logic             dec;
    logic             rd_valid;
  } item_t;

endpackage

>>> rtl/lewc_front.sv
`timescale 1ns / 1ps
module lewc_front (
  input  logic [lewc_pkg::WORD_W-1:0] raw_word,
  input  logic                        in_valid,
  input  logic                        q_full,
  output logic                        in_stall,
  output logic                        push,
  output lewc_pkg::item_t             item
);
  import lewc_pkg::*;

  always_comb begin
    item.cnt      = raw_word[CNT_LSB +: CNT_W];
    item.ocf      = raw_word[OCF_BIT];
    item.cof      = raw_word[COF_BIT];
    item.lin      = raw_word[LIN_BIT];
    item.inc      = raw_word[INC_BIT];
    item.dec      = raw_word[DEC_BIT];
    item.par_ok   = ~(^raw_word);  // even number of ones
    item.rd_valid = item.ocf && !item.cof && !item.lin &&
                    !(item.inc && item.dec) && item.par_ok;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

>>> rtl/lewc_queue.sv
`timescale 1ns / 1ps
module lewc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lewc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lewc_pkg::item_t pop_item,
  output logic            empty
);
  import lewc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QDEPTH);

  item_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count past depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> $stable(wr_ptr_r))
    else $error("queue written while full");

endmodule

>>> rtl/lewc_back.sv
`timescale 1ns / 1ps
module lewc_back #(
  parameter int POLE_BITS = lewc_pkg::POLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  lewc_pkg::cfg_idx_t                  cfg_index,
  input  logic [lewc_pkg::CNT_W-1:0]          cfg_data,
  input  logic                                q_empty,
  input  lewc_pkg::item_t                     q_item,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lewc_pkg::CNT_W-1:0]          out_in_pole_count,
  output logic signed [lewc_pkg::POS_W-1:0]   out_position_counts,
  output logic signed [lewc_pkg::TOTAL_W-1:0] out_pole_total,
  output logic                                out_word_valid,
  output logic                                out_parity_even,
  output logic                                out_offset_done,
  output logic                                out_cordic_overflow,
  output logic                                out_linearity_alarm,
  output logic                                out_field_increasing,
  output logic                                out_field_decreasing
);
  import lewc_pkg::*;

  localparam int POLE_HI_W = POS_W - CNT_W;
  localparam int EXT_W = (POLE_BITS > POLE_HI_W) ? POLE_BITS : POLE_HI_W;
  localparam logic signed [POLE_BITS-1:0] PMAX = {1'b0, {(POLE_BITS-1){1'b1}}};
  localparam logic signed [POLE_BITS-1:0] PMIN = {1'b1, {(POLE_BITS-1){1'b0}}};
  localparam logic signed [POLE_BITS-1:0] POLE_ONE = POLE_BITS'(1);

  logic [CNT_W-1:0]            high_thr_r, low_thr_r;
  logic [CNT_W-1:0]            last_count_r, last_count_nxt;
  logic signed [POLE_BITS-1:0] pole_r, pole_nxt, pole_mid, pole_fin;
  logic signed [EXT_W-1:0]     pole_ext;
  logic                        up, dn;
  logic                        out_valid_r, out_valid_nxt;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THR_RST;
      low_thr_r  <= LOW_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_HIGH_THR: high_thr_r <= cfg_data;
        CFG_LOW_THR:  low_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop = !q_empty && (!out_valid_r || !out_stall);

  // crossing rules tested in order; each saturates on its own
  always_comb begin
    up = q_item.rd_valid && (last_count_r > high_thr_r) && (q_item.cnt < low_thr_r);
    dn = q_item.rd_valid && (last_count_r < low_thr_r) && (q_item.cnt > high_thr_r);
    pole_mid = (up && pole_r != PMAX) ? pole_r + POLE_ONE : pole_r;
    pole_fin = (dn && pole_mid != PMIN) ? pole_mid - POLE_ONE : pole_mid;
    pole_ext = EXT_W'(pole_fin);
    pole_nxt = pop ? pole_fin : pole_r;
    last_count_nxt = (pop && q_item.rd_valid) ? q_item.cnt : last_count_r;
    out_valid_nxt  = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      pole_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      last_count_r <= last_count_nxt;
      pole_r       <= pole_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_in_pole_count    <= q_item.cnt;
      out_position_counts  <= $signed({pole_ext[POLE_HI_W-1:0], q_item.cnt});
      out_pole_total       <= $signed(pole_ext[TOTAL_W-1:0]);
      out_word_valid       <= q_item.rd_valid;
      out_parity_even      <= q_item.par_ok;
      out_offset_done      <= q_item.ocf;
      out_cordic_overflow  <= q_item.cof;
      out_linearity_alarm  <= q_item.lin;
      out_field_increasing <= q_item.inc;
      out_field_decreasing <= q_item.dec;
    end
  end

  assign out_valid = out_valid_r;

  a_invalid_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !q_item.rd_valid |=> $stable(last_count_r) && $stable(pole_r))
    else $error("rejected reading changed tracking state");

  a_pole_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (pole_r == $past(pole_r) || pole_r == $past(pole_r) + POLE_ONE ||
                      pole_r == $past(pole_r) - POLE_ONE))
    else $error("pole counter moved by more than one");

  a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop))
    else $error("result shown without a queue read");

endmodule

>>> rtl/linear_encoder_word_check_and_unwrap.sv
// Path: a word transferred in is written into the queue, then into the result register.
// Throughput: one word per cycle; the two-entry queue between decode and tracking
//   absorbs a stalled result register so the input keeps flowing until the queue fills.
// Reset (rst_n low, synchronous): queue and result register empty, last count and
//   pole counter zero, thresholds back to 3686 (high) and 410 (low).
`timescale 1ns / 1ps
module linear_encoder_word_check_and_unwrap #(
  parameter int POLE_BITS = lewc_pkg::POLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  lewc_pkg::cfg_idx_t                  cfg_index,
  input  logic [lewc_pkg::CNT_W-1:0]          cfg_data,
  // sensor words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lewc_pkg::WORD_W-1:0]         in_raw_word,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lewc_pkg::CNT_W-1:0]          out_in_pole_count,
  output logic signed [lewc_pkg::POS_W-1:0]   out_position_counts,
  output logic signed [lewc_pkg::TOTAL_W-1:0] out_pole_total,
  output logic                                out_word_valid,
  output logic                                out_parity_even,
  output logic                                out_offset_done,
  output logic                                out_cordic_overflow,
  output logic                                out_linearity_alarm,
  output logic                                out_field_increasing,
  output logic                                out_field_decreasing
);
  import lewc_pkg::*;

  item_t dec_item;   // decoded word from the front
  item_t q_item;     // head of the queue
  logic  push, pop, q_full, q_empty;

  // thresholds are plain registers, always writable
  assign cfg_ready = 1'b1;

  // Front: split the word, check parity and status flags. Stalls only when
  // the queue is full.
  lewc_front u_front (
    .raw_word (in_raw_word),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .item     (dec_item)
  );

  // Short queue decoupling decode from the tracking state.
  lewc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // Back: pole crossing detection against the thresholds, saturating pole
  // counter, position assembly and the result register.
  lewc_back #(
    .POLE_BITS (POLE_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .q_empty              (q_empty),
    .q_item               (q_item),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_in_pole_count    (out_in_pole_count),
    .out_position_counts  (out_position_counts),
    .out_pole_total       (out_pole_total),
    .out_word_valid       (out_word_valid),
    .out_parity_even      (out_parity_even),
    .out_offset_done      (out_offset_done),
    .out_cordic_overflow  (out_cordic_overflow),
    .out_linearity_alarm  (out_linearity_alarm),
    .out_field_increasing (out_field_increasing),
    .out_field_decreasing (out_field_decreasing)
  );

endmodule
